FILE: design/d2i_pkg.sv
// Package for the double to 64-bit integer converter.
// Holds field widths and saturation constants; no dependencies.
package d2i_pkg;

  localparam int unsigned ExpW     = 11;
  localparam int unsigned FracW    = 52;
  localparam int unsigned IntW     = 64;
  localparam int unsigned ExpBias  = 1023;

  localparam logic [ExpW-1:0] ExpAllOnes = '1;
  localparam logic [IntW-1:0] S64Max = {1'b0, {(IntW-1){1'b1}}};
  localparam logic [IntW-1:0] S64Min = {1'b1, {(IntW-1){1'b0}}};

  // Conversion modes.
  localparam logic OpSigned   = 1'b0;
  localparam logic OpUnsigned = 1'b1;

endpackage

FILE: design/double_to_int64_convert.sv
// Top level of the double to 64-bit integer converter.
// Depends on d2i_pkg for widths, modes and saturation constants.
//
// Usage:
// An operand is taken at each rising edge where start_i is high and busy_o
// is low. busy_o is always low, so one operand can enter every cycle.
// op_i selects signed (0) or unsigned (1) conversion of the raw binary64
// pattern value_bits_i, truncating toward zero with saturation.
// Each transaction yields one result on result_bits_o, marked by done_o for
// exactly one cycle, once the operand has passed through all register stages.
// Throughput is one transaction per cycle; operands pass through three register
// stages: field decode, alignment shift, and sign correction or saturation.
// Reset clears all valid bits; payload registers are not reset.
// The receiver cannot stall, so results leave in order without buffering.
module double_to_int64_convert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        op_i,
  input  logic [63:0] value_bits_i,
  output logic        done_o,
  output logic [63:0] result_bits_o
);

  // Result class decided in stage one.
  typedef enum logic [1:0] {
    ClsZero,
    ClsSatPos,
    ClsSatNeg,
    ClsNorm
  } cls_e;

  assign busy_o = 1'b0;

  // Stage one: decode fields and classify.
  logic        v1_q;
  cls_e        cls1_q, cls1_d;
  logic        neg1_q;
  logic [5:0]  e1_q;
  logic [52:0] sig1_q;

  logic        sgn;
  logic [10:0] bexp;
  logic [51:0] frac;
  logic        is_nan;
  logic        lt_one;

  always_comb begin
    sgn    = value_bits_i[63];
    bexp   = value_bits_i[62:52];
    frac   = value_bits_i[51:0];
    is_nan = (bexp == d2i_pkg::ExpAllOnes) && (frac != '0);
    lt_one = bexp < 11'(d2i_pkg::ExpBias);
    cls1_d = ClsNorm;
    if (op_i == d2i_pkg::OpSigned) begin
      if (is_nan || lt_one) begin
        cls1_d = ClsZero;
      end else if (bexp >= 11'(d2i_pkg::ExpBias + 63)) begin
        cls1_d = sgn ? ClsSatNeg : ClsSatPos;
      end
    end else begin
      if (sgn || is_nan || lt_one) begin
        cls1_d = ClsZero;
      end else if (bexp >= 11'(d2i_pkg::ExpBias + 64)) begin
        cls1_d = ClsSatPos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cls1_q <= cls1_d;
    // Unsigned saturation uses all ones; mark it with neg set.
    neg1_q <= (sgn && (op_i == d2i_pkg::OpSigned)) ||
              ((op_i == d2i_pkg::OpUnsigned) && (cls1_d == ClsSatPos));
    e1_q   <= 6'(bexp - 11'(d2i_pkg::ExpBias));
    sig1_q <= {1'b1, frac};
  end

  // Stage two: align the significand to the integer point.
  logic        v2_q;
  cls_e        cls2_q;
  logic        neg2_q;
  logic [63:0] mag2_q;
  logic [63:0] mag2_d;
  logic [63:0] sig_ext;

  always_comb begin
    sig_ext = {11'd0, sig1_q};
    if (e1_q >= 6'd52) begin
      mag2_d = sig_ext << (e1_q - 6'd52);
    end else begin
      mag2_d = sig_ext >> (6'd52 - e1_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cls2_q <= cls1_q;
    neg2_q <= neg1_q;
    mag2_q <= mag2_d;
  end

  // Stage three: negate or saturate and register the result.
  logic        v3_q;
  logic [63:0] res3_q, res3_d;

  always_comb begin
    unique case (cls2_q)
      ClsZero:   res3_d = '0;
      ClsSatPos: res3_d = neg2_q ? '1 : d2i_pkg::S64Max;
      ClsSatNeg: res3_d = d2i_pkg::S64Min;
      default:   res3_d = neg2_q ? (64'd0 - mag2_q) : mag2_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res3_q <= res3_d;
  end

  assign done_o        = v3_q;
  assign result_bits_o = res3_q;

endmodule

FILE: bench/tb_top.sv
// Testbench for the double to 64-bit integer converter.
// Drives raw binary64 operands in both modes and checks results against a local predictor.
// Depends on d2i_pkg and double_to_int64_convert.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NumRandom = 800;
  localparam int unsigned IdleLimit = 2000;

  typedef struct packed {
    logic        op;
    logic [63:0] value;
  } operand_t;

  logic        clk;
  logic        rst_n;
  logic        start = 1'b0;
  logic        busy;
  logic        op = 1'b0;
  logic [63:0] value_bits = '0;
  logic        done;
  logic [63:0] result_bits;

  operand_t    pending_q[$];
  logic [63:0] expected_int_q[$];
  int unsigned error_count = 0;
  int unsigned accepted_count = 0;
  int unsigned result_count = 0;
  int unsigned idle_cycles;
  int unsigned gap_left;
  bit          stimulus_done = 1'b0;

  double_to_int64_convert u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_o       (busy),
    .op_i         (op),
    .value_bits_i (value_bits),
    .done_o       (done),
    .result_bits_o(result_bits)
  );

  // Truncating conversion worked on the sign, exponent and fraction fields.
  function automatic logic [63:0] convert_double(logic mode, logic [63:0] bits);
    logic            neg;
    logic [10:0]     bexp;
    logic [51:0]     frac;
    int              e;
    logic [63:0]     sig;
    logic [63:0]     mag;
    neg  = bits[63];
    bexp = bits[62:52];
    frac = bits[51:0];
    if (bexp == d2i_pkg::ExpAllOnes && frac != '0) return '0;
    if (bexp == '0) return '0;
    if (mode == d2i_pkg::OpUnsigned && neg) return '0;
    e = int'(bexp) - int'(d2i_pkg::ExpBias);
    if (e < 0) return '0;
    if (mode == d2i_pkg::OpSigned && e >= 63) return neg ? d2i_pkg::S64Min : d2i_pkg::S64Max;
    if (mode == d2i_pkg::OpUnsigned && e >= 64) return '1;
    sig = {12'h001, frac};
    mag = (e >= 52) ? (sig << (e - 52)) : (sig >> (52 - e));
    if (mode == d2i_pkg::OpSigned && neg) return -mag;
    return mag;
  endfunction

  function automatic logic [63:0] pack_double(logic s, int unsigned bexp, logic [51:0] f);
    return {s, bexp[10:0], f};
  endfunction

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Reset and stimulus list.
  initial begin
    logic [51:0] frac;
    logic        sgn;
    int unsigned bexp;
    int unsigned kind;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // Directed operands: zeros, subnormals, boundaries, infinities and NaNs.
    for (int m = 0; m < 2; m++) begin
      pending_q.push_back('{m[0], 64'h0000_0000_0000_0000});
      pending_q.push_back('{m[0], 64'h8000_0000_0000_0000});
      pending_q.push_back('{m[0], 64'h000F_FFFF_FFFF_FFFF});
      pending_q.push_back('{m[0], 64'h3FEF_FFFF_FFFF_FFFF});
      pending_q.push_back('{m[0], 64'h3FF0_0000_0000_0000});
      pending_q.push_back('{m[0], 64'hBFF8_0000_0000_0000});
      pending_q.push_back('{m[0], 64'h43DF_FFFF_FFFF_FFFF});
      pending_q.push_back('{m[0], 64'h43E0_0000_0000_0000});
      pending_q.push_back('{m[0], 64'hC3E0_0000_0000_0000});
      pending_q.push_back('{m[0], 64'h43EF_FFFF_FFFF_FFFF});
      pending_q.push_back('{m[0], 64'h43F0_0000_0000_0000});
      pending_q.push_back('{m[0], 64'h7FF0_0000_0000_0000});
      pending_q.push_back('{m[0], 64'hFFF0_0000_0000_0000});
      pending_q.push_back('{m[0], 64'hFFFF_FFFF_FFFF_FFFF});
    end
    // Random operands, mostly with exponents in the interesting range.
    for (int unsigned i = 0; i < NumRandom; i++) begin
      frac = 52'({$urandom(), $urandom()});
      sgn  = 1'($urandom_range(0, 1));
      kind = $urandom_range(0, 9);
      if (kind < 6) bexp = $urandom_range(1016, 1090);
      else if (kind < 8) bexp = $urandom_range(0, 2047);
      else bexp = ($urandom_range(0, 1) != 0) ? 2047 : 0;
      if (kind == 9) pending_q.push_back('{1'($urandom_range(0, 1)), {$urandom(), $urandom()}});
      else pending_q.push_back('{1'($urandom_range(0, 1)), pack_double(sgn, bexp, frac)});
    end
    stimulus_done = 1'b1;
  end

  // Driver: issues one transaction at a time after a random gap.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      start      <= 1'b0;
      op         <= 1'b0;
      value_bits <= '0;
      gap_left   <= 0;
    end else begin
      if (start && !busy) begin
        expected_int_q.push_back(convert_double(op, value_bits));
        accepted_count <= accepted_count + 1;
      end
      if (start && busy) begin
        // Hold the current transaction.
      end else if (gap_left != 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() != 0) begin
        operand_t item;
        item       = pending_q.pop_front();
        start      <= 1'b1;
        op         <= item.op;
        value_bits <= item.value;
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compares each result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && done) begin
      result_count <= result_count + 1;
      if (expected_int_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, result_bits);
        error_count <= error_count + 1;
      end else begin
        logic [63:0] want;
        want = expected_int_q.pop_front();
        if (want !== result_bits) begin
          $display("%0t: result_bits mismatch, expected %h, actual %h",
                   $time, want, result_bits);
          error_count <= error_count + 1;
        end
      end
    end
  end

  // Watchdog and end of run.
  initial begin
    idle_cycles = 0;
    @(posedge rst_n);
    while (!(stimulus_done && pending_q.size() == 0 && !start && expected_int_q.size() == 0)
           && idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      repeat (10) @(posedge clk);
      $display("Converted %0d operands in signed and unsigned mode; %0d results checked.",
               accepted_count, result_count);
      if (error_count == 0 && expected_int_q.size() == 0) begin
        $display("SCOREBOARD CLEAN");
      end else begin
        $display("SCOREBOARD MISMATCH");
      end
      $finish;
    end
  end

endmodule
